// ===== src/mmrq_pkg.sv =====
// Shared types and constants for the mailbox ring queue block.
package mmrq_pkg;

   // Field widths fixed by the interface
   localparam int CAP_W      = 4;
   localparam int FILL_W     = 4;
   localparam int BOX_ID_W   = 2;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int NUM_CFG_REGS = 3;

   // Operation codes
   localparam logic MODE_SEND = 1'b0;
   localparam logic MODE_RECV = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic execute;
   } ctrl_cmd_type;

endpackage

// ===== src/mmrq_ctrl.sv =====
// Handshake controller: sequences capture, execute and response of one beat.
module mmrq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mmrq_pkg::ctrl_cmd_type cmd
);

   mmrq_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mmrq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mmrq_pkg::ST_IDLE: begin
            if (req_valid) state_in = mmrq_pkg::ST_EXEC;
         end
         mmrq_pkg::ST_EXEC: begin
            state_in = mmrq_pkg::ST_RESP;
         end
         mmrq_pkg::ST_RESP: begin
            if (rsp_ready) state_in = mmrq_pkg::ST_IDLE;
         end
         default: begin
            state_in = mmrq_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         mmrq_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         mmrq_pkg::ST_EXEC: begin
            cmd.execute = 1'b1;
         end
         mmrq_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ===== src/mmrq_datapath.sv =====
// Mailbox datapath: capacity registers, ring pointers, slot memory, result registers.
module mmrq_datapath #(
   parameter int NUM_BOXES     = 3,
   parameter int SLOTS_PER_BOX = 16,
   parameter int HANDLE_BITS   = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mmrq_pkg::ctrl_cmd_type             cmd,
   input  logic                               req_mode,
   input  logic [mmrq_pkg::BOX_ID_W-1:0]      req_box_id,
   input  logic [HANDLE_BITS-1:0]             req_msg_handle,
   input  logic                               csr_wr_en,
   input  logic [mmrq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mmrq_pkg::CAP_W-1:0]         csr_wdata,
   output logic [mmrq_pkg::STATUS_W-1:0]      rsp_status,
   output logic [HANDLE_BITS-1:0]             rsp_handle_out,
   output logic [mmrq_pkg::FILL_W-1:0]        rsp_fill_level
);

   localparam int PW    = (SLOTS_PER_BOX > 2) ? $clog2(SLOTS_PER_BOX) : 1;
   localparam int EW    = (PW > mmrq_pkg::CAP_W) ? PW : mmrq_pkg::CAP_W;
   localparam int BW    = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1;
   localparam int DEPTH = NUM_BOXES * SLOTS_PER_BOX;
   localparam int AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;

   // Captured request
   logic                          mode_ff;
   logic [mmrq_pkg::BOX_ID_W-1:0] box_ff;
   logic [HANDLE_BITS-1:0]        handle_ff;

   // Per-box state
   logic [mmrq_pkg::CAP_W-1:0] cap_ff    [NUM_BOXES];
   logic [mmrq_pkg::CAP_W-1:0] cap_in    [NUM_BOXES];
   logic [PW-1:0]              rd_ptr_ff [NUM_BOXES];
   logic [PW-1:0]              rd_ptr_in [NUM_BOXES];
   logic [PW-1:0]              wr_ptr_ff [NUM_BOXES];
   logic [PW-1:0]              wr_ptr_in [NUM_BOXES];

   // Result registers
   logic [mmrq_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [mmrq_pkg::FILL_W-1:0]   fill_ff, fill_in;
   logic                          recv_ok_ff, recv_ok_in;
   logic [HANDLE_BITS-1:0]        rdata_ff;

   logic [HANDLE_BITS-1:0] slot_mem [DEPTH];

   logic                       box_in_range;
   logic [BW-1:0]              box_sel;
   logic [mmrq_pkg::CAP_W-1:0] cap_sel;
   logic                       created;
   logic [PW-1:0]              rp, wp, rp_next, wp_next, rp_post, wp_post;
   logic                       full, empty;
   logic                       mem_we, mem_re;
   logic [AW-1:0]              mem_addr;
   logic [EW:0]                fill_calc;
   logic                       csr_hit;
   logic [BW-1:0]              csr_box;
   logic [mmrq_pkg::CAP_W-1:0] cap_sat;

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff   <= req_mode;
         box_ff    <= req_box_id;
         handle_ff <= req_msg_handle;
      end
   end

   // Box decode
   always_comb begin
      box_in_range = (32'(box_ff) < 32'(NUM_BOXES));
      box_sel      = box_in_range ? BW'(box_ff) : '0;
      cap_sel      = cap_ff[box_sel];
      created      = box_in_range && (cap_sel != '0);
      rp           = rd_ptr_ff[box_sel];
      wp           = wr_ptr_ff[box_sel];
      // Wrap at capacity + 1 slots
      rp_next      = (EW'(rp) == EW'(cap_sel)) ? '0 : PW'(rp + 1'b1);
      wp_next      = (EW'(wp) == EW'(cap_sel)) ? '0 : PW'(wp + 1'b1);
      full         = (wp_next == rp);
      empty        = (rp == wp);
   end

   // Configuration decode with capacity saturation
   always_comb begin
      csr_hit = csr_wr_en && (32'(csr_index) < 32'(mmrq_pkg::NUM_CFG_REGS))
                && (32'(csr_index) < 32'(NUM_BOXES));
      csr_box = BW'(csr_index);
      cap_sat = (EW'(csr_wdata) > EW'(SLOTS_PER_BOX - 1))
                ? mmrq_pkg::CAP_W'(SLOTS_PER_BOX - 1) : csr_wdata;
   end

   // Operation
   always_comb begin
      cap_in     = cap_ff;
      rd_ptr_in  = rd_ptr_ff;
      wr_ptr_in  = wr_ptr_ff;
      status_in  = status_ff;
      fill_in    = fill_ff;
      recv_ok_in = recv_ok_ff;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      rp_post    = rp;
      wp_post    = wp;
      fill_calc  = '0;

      if (csr_hit) begin
         // Writing a capacity empties the box
         cap_in[csr_box]    = cap_sat;
         rd_ptr_in[csr_box] = '0;
         wr_ptr_in[csr_box] = '0;
      end

      if (cmd.execute) begin
         recv_ok_in = 1'b0;
         status_in  = mmrq_pkg::STATUS_OK;
         if (!created) begin
            status_in = mmrq_pkg::STATUS_BAD;
         end else if (mode_ff == mmrq_pkg::MODE_SEND) begin
            if (full) begin
               status_in = mmrq_pkg::STATUS_FULL;
            end else begin
               mem_we             = 1'b1;
               wp_post            = wp_next;
               wr_ptr_in[box_sel] = wp_next;
            end
         end else begin
            if (empty) begin
               status_in = mmrq_pkg::STATUS_EMPTY;
            end else begin
               mem_re             = 1'b1;
               recv_ok_in         = 1'b1;
               rp_post            = rp_next;
               rd_ptr_in[box_sel] = rp_next;
            end
         end

         if (wp_post >= rp_post) begin
            fill_calc = (EW+1)'(wp_post) - (EW+1)'(rp_post);
         end else begin
            fill_calc = (EW+1)'(wp_post) + (EW+1)'(cap_sel) + 1'b1 - (EW+1)'(rp_post);
         end
         fill_in = created ? mmrq_pkg::FILL_W'(fill_calc) : '0;
      end
   end

   always_comb begin
      mem_addr = AW'(AW'(box_sel) * AW'(SLOTS_PER_BOX))
                 + ((mode_ff == mmrq_pkg::MODE_RECV) ? AW'(rp) : AW'(wp));
   end

   // Slot memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) slot_mem[mem_addr] <= handle_ff;
      if (mem_re) rdata_ff <= slot_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BOXES; i++) begin
            cap_ff[i]    <= '0;
            rd_ptr_ff[i] <= '0;
            wr_ptr_ff[i] <= '0;
         end
         recv_ok_ff <= 1'b0;
      end else begin
         cap_ff     <= cap_in;
         rd_ptr_ff  <= rd_ptr_in;
         wr_ptr_ff  <= wr_ptr_in;
         recv_ok_ff <= recv_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      fill_ff   <= fill_in;
   end

   assign rsp_status     = status_ff;
   assign rsp_fill_level = fill_ff;
   assign rsp_handle_out = recv_ok_ff ? rdata_ff : '0;

endmodule

// ===== src/multi_mailbox_ring_queues_top.sv =====
// Top level of the multi-mailbox ring queue block.
//
//   channel   ports                                    direction
//   request   req_valid/req_ready, mode, box_id, handle in
//   response  rsp_valid/rsp_ready, status, handle, fill out
//   config    csr_wr_en, csr_index, csr_wdata          in (write only)
//
// Each beat passes through the states accept, execute (slot memory access and
// pointer update) and response. Receive data comes from the registered memory
// read port. A new request is taken only after the response beat is taken.
// Reset clears all capacities and pointers; no mailbox exists until written.
// The response holds while rsp_ready is low.
module multi_mailbox_ring_queues_top #(
   parameter int NUM_BOXES     = 3,
   parameter int SLOTS_PER_BOX = 16,
   parameter int HANDLE_BITS   = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_mode,
   input  logic [mmrq_pkg::BOX_ID_W-1:0]  req_box_id,
   input  logic [HANDLE_BITS-1:0]         req_msg_handle,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [mmrq_pkg::STATUS_W-1:0]  rsp_status,
   output logic [HANDLE_BITS-1:0]         rsp_handle_out,
   output logic [mmrq_pkg::FILL_W-1:0]    rsp_fill_level,
   input  logic                           csr_wr_en,
   input  logic [mmrq_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mmrq_pkg::CAP_W-1:0]     csr_wdata
);

   mmrq_pkg::ctrl_cmd_type cmd;

   mmrq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   mmrq_datapath #(
      .NUM_BOXES     (NUM_BOXES),
      .SLOTS_PER_BOX (SLOTS_PER_BOX),
      .HANDLE_BITS   (HANDLE_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_mode       (req_mode),
      .req_box_id     (req_box_id),
      .req_msg_handle (req_msg_handle),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_status     (rsp_status),
      .rsp_handle_out (rsp_handle_out),
      .rsp_fill_level (rsp_fill_level)
   );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the multi-mailbox ring queue block.
module tb_top;

   localparam int BOXES        = 3;
   localparam int SLOTS        = 16;
   localparam int HANDLE_W     = 16;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int MAX_REPORTS  = 10;
   localparam int STATUS_W     = mmrq_pkg::STATUS_W;
   localparam int FILL_W       = mmrq_pkg::FILL_W;
   localparam int BOX_ID_W     = mmrq_pkg::BOX_ID_W;
   localparam int CSR_IDX_W    = mmrq_pkg::CSR_IDX_W;
   localparam int CAP_W        = mmrq_pkg::CAP_W;
   localparam int NUM_CFG_REGS = mmrq_pkg::NUM_CFG_REGS;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [HANDLE_W-1:0] handle;
      logic [FILL_W-1:0]   fill;
   } mbox_reply_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_mode = mmrq_pkg::MODE_SEND;
   logic [BOX_ID_W-1:0]   req_box_id = '0;
   logic [HANDLE_W-1:0]   req_msg_handle = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [HANDLE_W-1:0]   rsp_handle_out;
   logic [FILL_W-1:0]     rsp_fill_level;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CAP_W-1:0]      csr_wdata = '0;

   // Mailbox state as the block should hold it
   int                    box_cap [BOXES];
   int                    head_idx [BOXES];
   int                    tail_idx [BOXES];
   logic [HANDLE_W-1:0]   slot_mem [BOXES][SLOTS];

   mbox_reply_type        pending_replies [$];
   int unsigned           fail_count = 0;
   int unsigned           cycle_count = 0;
   int unsigned           send_idle_pct = 0;
   int unsigned           rsp_stall_pct = 0;
   int unsigned           hold_req_id = 0;
   int unsigned           hold_len = 0;

   multi_mailbox_ring_queues_top #(
      .NUM_BOXES    (BOXES),
      .SLOTS_PER_BOX(SLOTS),
      .HANDLE_BITS  (HANDLE_W)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_box_id    (req_box_id),
      .req_msg_handle(req_msg_handle),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_handle_out(rsp_handle_out),
      .rsp_fill_level(rsp_fill_level),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Apply one operation to the mailbox state and return its reply
   function automatic mbox_reply_type mailbox_op(logic mode, logic [BOX_ID_W-1:0] box,
                                                 logic [HANDLE_W-1:0] handle);
      mbox_reply_type r;
      int             ring_len;
      int             nxt;
      r = '0;
      r.status = mmrq_pkg::STATUS_BAD;
      if (box >= BOXES || box_cap[box] == 0)
         return r;
      ring_len = box_cap[box] + 1;
      r.status = mmrq_pkg::STATUS_OK;
      if (mode == mmrq_pkg::MODE_SEND) begin
         nxt = (tail_idx[box] + 1) % ring_len;
         if (nxt == head_idx[box]) begin
            r.status = mmrq_pkg::STATUS_FULL;
         end else begin
            slot_mem[box][tail_idx[box]] = handle;
            tail_idx[box] = nxt;
         end
      end else begin
         if (head_idx[box] == tail_idx[box]) begin
            r.status = mmrq_pkg::STATUS_EMPTY;
         end else begin
            r.handle = slot_mem[box][head_idx[box]];
            head_idx[box] = (head_idx[box] + 1) % ring_len;
         end
      end
      r.fill = FILL_W'((tail_idx[box] + ring_len - head_idx[box]) % ring_len);
      return r;
   endfunction

   task automatic flag_error(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("ERROR @%0d: %s", cycle_count, msg);
   endtask

   // Predict on each request beat, then check each response beat
   always @(posedge clock) begin : reply_check
      mbox_reply_type want;
      mbox_reply_type got;
      if (!reset && req_valid && req_ready)
         pending_replies.push_back(mailbox_op(req_mode, req_box_id, req_msg_handle));
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{status: rsp_status, handle: rsp_handle_out, fill: rsp_fill_level};
         if (pending_replies.size() == 0) begin
            flag_error($sformatf("response beat with nothing pending: %0d %h %0d",
                                 got.status, got.handle, got.fill));
         end else begin
            want = pending_replies.pop_front();
            if (got.status !== want.status || got.handle !== want.handle ||
                got.fill !== want.fill)
               flag_error($sformatf("expected status %0d handle %h fill %0d, got %0d %h %0d",
                                    want.status, want.handle, want.fill,
                                    got.status, got.handle, got.fill));
         end
      end
   end

   // Output side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin : rsp_side
      int unsigned hold_left;
      int unsigned hold_seen_id;
      if (hold_seen_id != hold_req_id) begin
         hold_seen_id = hold_req_id;
         hold_left = hold_len;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   task automatic send_op(input logic mode, input logic [BOX_ID_W-1:0] box,
                          input logic [HANDLE_W-1:0] handle);
      int unsigned gap;
      gap = 0;
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_box_id     <= box;
      req_msg_handle <= handle;
      do @(posedge clock); while (!req_ready);
      while (gap < 20 && $urandom_range(0, 99) < send_idle_pct)
         gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every reply is back and the block is quiet
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_capacity(input int idx, input logic [CAP_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_IDX_W'(idx);
      csr_wdata <= value;
      @(posedge clock);
      // A write empties the box; out-of-range indexes are ignored
      if (idx < NUM_CFG_REGS && idx < BOXES) begin
         box_cap[idx]  = (value > SLOTS - 1) ? SLOTS - 1 : value;
         head_idx[idx] = 0;
         tail_idx[idx] = 0;
      end
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [CAP_W-1:0] pick_capacity();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0)
         return '0;
      if (roll <= 2)
         return CAP_W'(1);
      if (roll <= 4)
         return CAP_W'(15);
      return CAP_W'($urandom_range(1, 14));
   endfunction

   task automatic test_directed_cases();
      int i;
      // Nothing exists after reset
      send_op(mmrq_pkg::MODE_SEND, 2'd0, 16'hFFFF);
      send_op(mmrq_pkg::MODE_RECV, 2'd1, 16'h0000);
      send_op(mmrq_pkg::MODE_RECV, 2'd3, 16'h0000);
      wait_idle();
      write_capacity(0, 4'd1);
      write_capacity(1, 4'd15);
      write_capacity(2, 4'd2);
      write_capacity(3, 4'hF);
      // Single-entry box: full and empty
      send_op(mmrq_pkg::MODE_SEND, 2'd0, 16'hFFFF);
      send_op(mmrq_pkg::MODE_SEND, 2'd0, 16'h0000);
      send_op(mmrq_pkg::MODE_RECV, 2'd0, 16'h1234);
      send_op(mmrq_pkg::MODE_RECV, 2'd0, 16'h0000);
      send_op(mmrq_pkg::MODE_SEND, 2'd3, 16'hA5A5);
      send_op(mmrq_pkg::MODE_RECV, 2'd3, 16'h5A5A);
      send_op(mmrq_pkg::MODE_SEND, 2'd2, 16'hA5A5);
      send_op(mmrq_pkg::MODE_SEND, 2'd2, 16'h5A5A);
      send_op(mmrq_pkg::MODE_SEND, 2'd2, 16'h1234);
      send_op(mmrq_pkg::MODE_RECV, 2'd2, 16'h0000);
      send_op(mmrq_pkg::MODE_RECV, 2'd2, 16'h0000);
      send_op(mmrq_pkg::MODE_RECV, 2'd2, 16'h0000);
      for (i = 0; i < 3; i++)
         send_op(mmrq_pkg::MODE_SEND, 2'd1, 16'(16'h8001 << i));
      wait_idle();
      // Rewriting a capacity empties the box; capacity zero removes it
      write_capacity(1, 4'd15);
      write_capacity(2, 4'd0);
      send_op(mmrq_pkg::MODE_RECV, 2'd1, 16'h0000);
      send_op(mmrq_pkg::MODE_SEND, 2'd2, 16'h7777);
      wait_idle();
   endtask

   task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                      input int n_items);
      int                  issued;
      int                  burst;
      int                  i;
      int unsigned         send_bias;
      logic [BOX_ID_W-1:0] box;
      logic [BOX_ID_W-1:0] target;
      logic                mode;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      issued = 0;
      while (issued < n_items) begin
         box = ($urandom_range(0, 19) == 0) ? 2'd3 : BOX_ID_W'($urandom_range(0, 2));
         case ($urandom_range(0, 2))
            0: send_bias = 85;
            1: send_bias = 15;
            default: send_bias = 50;
         endcase
         burst = $urandom_range(4, 32);
         for (i = 0; i < burst && issued < n_items; i++) begin
            mode = ($urandom_range(0, 99) < send_bias) ? mmrq_pkg::MODE_SEND
                                                        : mmrq_pkg::MODE_RECV;
            target = ($urandom_range(0, 9) == 0) ? BOX_ID_W'($urandom_range(0, 3)) : box;
            send_op(mode, target, HANDLE_W'($urandom_range(0, 65535)));
            issued++;
         end
      end
      wait_idle();
   endtask

   task automatic test_output_stall();
      int i;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_len = 300;
      hold_req_id++;
      // Keep offering beats while the output is held off
      for (i = 0; i < 24; i++)
         send_op((i % 3 == 2) ? mmrq_pkg::MODE_RECV : mmrq_pkg::MODE_SEND,
                 BOX_ID_W'(i % 3), HANDLE_W'($urandom_range(0, 65535)));
      wait_idle();
   endtask

   task automatic reprogram_boxes();
      int b;
      for (b = 0; b < BOXES; b++)
         write_capacity(b, pick_capacity());
      write_capacity(3, CAP_W'($urandom_range(0, 15)));
   endtask

   initial begin : run
      int phase;
      int unsigned idle_tbl [4];
      int unsigned stall_tbl [4];
      idle_tbl  = '{0, 52, 0, 15};
      stall_tbl = '{0, 0, 52, 15};
      for (int b = 0; b < BOXES; b++) begin
         box_cap[b]  = 0;
         head_idx[b] = 0;
         tail_idx[b] = 0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      for (phase = 0; phase < 4; phase++) begin
         write_capacity(0, 4'd15);
         write_capacity(1, 4'd1);
         write_capacity(2, CAP_W'($urandom_range(2, 14)));
         test_random_traffic(idle_tbl[phase], stall_tbl[phase], 230);
         reprogram_boxes();
         test_random_traffic(idle_tbl[phase], stall_tbl[phase], 230);
      end
      write_capacity(0, 4'd2);
      write_capacity(1, 4'd15);
      write_capacity(2, 4'd1);
      test_output_stall();
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
